/* hdl/render_state_change_filter_macros.svh */
// assertion macros for the render state change filter checker
// used by render_state_change_filter_chk.sv, no other dependencies
`ifndef RENDER_STATE_CHANGE_FILTER_MACROS_SVH
`define RENDER_STATE_CHANGE_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RSCF_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RSCF_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rscf_pkg.sv */
// shared types, state numbers and decode functions of the render state change filter
// no dependencies; used by every module of the block
package rscf_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_FLUSH   = 2'd0,
        KIND_RENDER  = 2'd1,
        KIND_SAMPLER = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    // render state numbers
    localparam logic [7:0] RS_BLEND_ENABLE = 8'd15;
    localparam logic [7:0] RS_MATERIAL_0   = 8'd206;
    localparam logic [7:0] RS_MATERIAL_1   = 8'd207;
    localparam logic [7:0] RS_MATERIAL_2   = 8'd208;
    localparam logic [7:0] RS_MATERIAL_3   = 8'd209;
    localparam logic [7:0] RS_SRC_BLEND    = 8'd19;
    localparam logic [7:0] RS_DST_BLEND    = 8'd20;
    localparam logic [7:0] RS_BLEND_OP     = 8'd171;

    // sampler state numbers
    localparam logic [7:0] SS_ADDR_U = 8'd1;
    localparam logic [7:0] SS_ADDR_V = 8'd2;
    localparam logic [7:0] SS_MAG    = 8'd5;
    localparam logic [7:0] SS_MIN    = 8'd6;

    localparam logic [7:0] ADDR_MODE_NONE = 8'd3;

    // one step of the fixed write script, in emission order
    localparam int NUM_STEPS = 18;
    typedef enum logic [4:0] {
        ST_B_FLUSH   = 5'd0,
        ST_B_ENABLE  = 5'd1,
        ST_B_MAT0    = 5'd2,
        ST_B_MAT1    = 5'd3,
        ST_B_MAT2    = 5'd4,
        ST_B_MAT3    = 5'd5,
        ST_B_DISABLE = 5'd6,
        ST_B_SRC     = 5'd7,
        ST_B_DST     = 5'd8,
        ST_B_OP      = 5'd9,
        ST_F_FLUSH   = 5'd10,
        ST_F_MAG     = 5'd11,
        ST_F_MIN     = 5'd12,
        ST_U_FLUSH   = 5'd13,
        ST_U_ADDR    = 5'd14,
        ST_V_FLUSH   = 5'd15,
        ST_V_ADDR    = 5'd16,
        ST_DONE      = 5'd17
    } step_t;

    typedef logic [NUM_STEPS-1:0] mask_t;

    // one classified sprite, front to back
    typedef struct packed {
        mask_t       steps;
        logic [7:0]  blend;
        logic [1:0]  filter;
        logic [1:0]  u_mode;
        logic [1:0]  v_mode;
        logic [31:0] count;
    } job_t;

    localparam int QUEUE_DEPTH = 4;

    // result payload without the counter fields
    typedef struct packed {
        kind_t      kind;
        logic [7:0] id;
        logic [3:0] value;
    } write_t;

    // blend code to source, destination and operation
    function automatic logic [3:0] blend_src(input logic [7:0] code);
        logic [3:0] v;
        v = 4'd5;
        unique case (code)
            8'd3: v = 4'd2;
            8'd4: v = 4'd10;
            8'd5: v = 4'd9;
            8'd6: v = 4'd4;
            8'd7: v = 4'd7;
            default: v = 4'd5;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] blend_dst(input logic [7:0] code);
        logic [3:0] v;
        v = 4'd6;
        unique case (code)
            8'd1, 8'd2, 8'd8, 8'd9: v = 4'd2;
            8'd3, 8'd5: v = 4'd1;
            8'd4: v = 4'd4;
            8'd7: v = 4'd8;
            default: v = 4'd6;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] blend_op(input logic [7:0] code);
        logic [3:0] v;
        v = 4'd1;
        unique case (code)
            8'd2: v = 4'd3;
            8'd8: v = 4'd4;
            8'd9: v = 4'd5;
            default: v = 4'd1;
        endcase
        return v;
    endfunction

    // address mode to sampler value (mode 3 never reaches here)
    function automatic logic [3:0] addr_value(input logic [1:0] mode);
        logic [3:0] v;
        v = 4'd2;
        unique case (mode)
            2'd0: v = 4'd1;
            2'd1: v = 4'd3;
            default: v = 4'd2;
        endcase
        return v;
    endfunction

    // payload of one script step
    function automatic write_t step_write(input step_t st, input job_t j);
        write_t     w;
        logic [3:0] fv;
        fv = (j.filter == 2'd0) ? 4'd2 : 4'd1;
        w  = '{kind: KIND_FLUSH, id: 8'd0, value: 4'd0};
        unique case (st)
            ST_B_FLUSH, ST_F_FLUSH, ST_U_FLUSH, ST_V_FLUSH:
                w = '{kind: KIND_FLUSH, id: 8'd0, value: 4'd0};
            ST_B_ENABLE:  w = '{kind: KIND_RENDER, id: RS_BLEND_ENABLE, value: 4'd1};
            ST_B_MAT0:    w = '{kind: KIND_RENDER, id: RS_MATERIAL_0, value: 4'd1};
            ST_B_MAT1:    w = '{kind: KIND_RENDER, id: RS_MATERIAL_1, value: 4'd2};
            ST_B_MAT2:    w = '{kind: KIND_RENDER, id: RS_MATERIAL_2, value: 4'd1};
            ST_B_MAT3:    w = '{kind: KIND_RENDER, id: RS_MATERIAL_3, value: 4'd1};
            ST_B_DISABLE: w = '{kind: KIND_RENDER, id: RS_BLEND_ENABLE, value: 4'd0};
            ST_B_SRC:     w = '{kind: KIND_RENDER, id: RS_SRC_BLEND, value: blend_src(j.blend)};
            ST_B_DST:     w = '{kind: KIND_RENDER, id: RS_DST_BLEND, value: blend_dst(j.blend)};
            ST_B_OP:      w = '{kind: KIND_RENDER, id: RS_BLEND_OP, value: blend_op(j.blend)};
            ST_F_MAG:     w = '{kind: KIND_SAMPLER, id: SS_MAG, value: fv};
            ST_F_MIN:     w = '{kind: KIND_SAMPLER, id: SS_MIN, value: fv};
            ST_U_ADDR:    w = '{kind: KIND_SAMPLER, id: SS_ADDR_U, value: addr_value(j.u_mode)};
            ST_V_ADDR:    w = '{kind: KIND_SAMPLER, id: SS_ADDR_V, value: addr_value(j.v_mode)};
            ST_DONE:      w = '{kind: KIND_DONE, id: 8'd0, value: 4'd0};
            default:      w = '{kind: KIND_FLUSH, id: 8'd0, value: 4'd0};
        endcase
        return w;
    endfunction

endpackage

/* hdl/render_state_change_filter.sv */
// top level of the render state change filter: front end, job queue, back end
// depends on rscf_pkg, rscf_front, rscf_queue, rscf_back
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  in      | in_valid / in_ready  | flags_word0, flags_word2
//  out     | out_valid / out_ready| kind, state_id, state_value, sprite_count, last
//
// each sprite yields from 1 result (done only) up to 18 results, the most when every field
// changed; the back-end step walker emits one result per clock while out_ready does not stall it
// in_ready drops only when the four-entry job queue is full
// a sprite's first result passes the queue entry register, then the output register
// reset clears the cache to "unknown" (blend 255) and the sprite counter to zero
module render_state_change_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] flags_word0,
    input  logic [31:0] flags_word2,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  state_id,
    output logic [3:0]  state_value,
    output logic [31:0] sprite_count,
    output logic        last
);

    logic           push;
    rscf_pkg::job_t push_job;
    logic           q_full;
    logic           pop;
    logic           head_valid;
    rscf_pkg::job_t head_job;

    // classify and cache
    rscf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .flags_word0 (flags_word0),
        .flags_word2 (flags_word2),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    // decoupling queue
    rscf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // emit write sequences
    rscf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .state_id     (state_id),
        .state_value  (state_value),
        .sprite_count (sprite_count),
        .last         (last)
    );

endmodule

/* hdl/rscf_front.sv */
// front end: accepts sprites, compares decoded fields with the cache, builds step masks
// depends on rscf_pkg
module rscf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        flags_word0,
    input  logic [31:0]        flags_word2,
    input  logic               q_full,
    output logic               push,
    output rscf_pkg::job_t     push_job
);

    logic [7:0]  blend_reg;
    logic [7:0]  blend_next;
    logic        filter_known_reg;
    logic [1:0]  filter_reg;
    logic        u_known_reg;
    logic [1:0]  u_reg;
    logic        v_known_reg;
    logic [1:0]  v_reg;
    logic [31:0] count_reg;
    logic [31:0] count_next;

    logic [7:0]  blend;
    logic [1:0]  filter;
    logic [1:0]  u_mode;
    logic [1:0]  v_mode;
    logic        blend_chg;
    logic        filter_chg;
    logic        u_chg;
    logic        v_chg;
    rscf_pkg::mask_t steps;

    // field decode
    assign blend  = flags_word0[15:8];
    assign filter = flags_word2[3:2];
    assign u_mode = flags_word2[17:16];
    assign v_mode = flags_word2[14:13];

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // change detection against cache
    assign blend_chg  = blend != blend_reg;
    assign filter_chg = !filter_known_reg || (filter != filter_reg);
    assign u_chg      = !u_known_reg || (u_mode != u_reg);
    assign v_chg      = !v_known_reg || (v_mode != v_reg);

    // steps this sprite will emit
    always_comb
    begin
        steps = '0;
        steps[rscf_pkg::ST_B_FLUSH]   = blend_chg;
        steps[rscf_pkg::ST_B_ENABLE]  = blend_chg;
        steps[rscf_pkg::ST_B_MAT0]    = blend_chg;
        steps[rscf_pkg::ST_B_MAT1]    = blend_chg;
        steps[rscf_pkg::ST_B_MAT2]    = blend_chg;
        steps[rscf_pkg::ST_B_MAT3]    = blend_chg;
        steps[rscf_pkg::ST_B_DISABLE] = blend_chg && (blend == 8'd3);
        steps[rscf_pkg::ST_B_SRC]     = blend_chg;
        steps[rscf_pkg::ST_B_DST]     = blend_chg;
        steps[rscf_pkg::ST_B_OP]      = blend_chg;
        steps[rscf_pkg::ST_F_FLUSH]   = filter_chg;
        steps[rscf_pkg::ST_F_MAG]     = filter_chg;
        steps[rscf_pkg::ST_F_MIN]     = filter_chg;
        steps[rscf_pkg::ST_U_FLUSH]   = u_chg;
        steps[rscf_pkg::ST_U_ADDR]    = u_chg && ({6'd0, u_mode} != rscf_pkg::ADDR_MODE_NONE);
        steps[rscf_pkg::ST_V_FLUSH]   = v_chg;
        steps[rscf_pkg::ST_V_ADDR]    = v_chg && ({6'd0, v_mode} != rscf_pkg::ADDR_MODE_NONE);
        steps[rscf_pkg::ST_DONE]      = 1'b1;
    end

    assign count_next = count_reg + 32'd1;
    assign blend_next = blend;

    assign push_job = '{steps: steps, blend: blend, filter: filter, u_mode: u_mode,
                        v_mode: v_mode, count: count_next};

    // cache and counter update on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg        <= 8'hff;
            filter_known_reg <= 1'b0;
            filter_reg       <= 2'd0;
            u_known_reg      <= 1'b0;
            u_reg            <= 2'd0;
            v_known_reg      <= 1'b0;
            v_reg            <= 2'd0;
            count_reg        <= 32'd0;
        end
        else if (push)
        begin
            blend_reg        <= blend_next;
            filter_known_reg <= 1'b1;
            filter_reg       <= filter;
            u_known_reg      <= 1'b1;
            u_reg            <= u_mode;
            v_known_reg      <= 1'b1;
            v_reg            <= v_mode;
            count_reg        <= count_next;
        end
    end

endmodule

/* hdl/rscf_queue.sv */
// short job queue between front and back end
// depends on rscf_pkg
module rscf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rscf_pkg::job_t     push_job,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output rscf_pkg::job_t     head_job
);

    localparam int PTR_W = $clog2(rscf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rscf_pkg::QUEUE_DEPTH + 1);

    rscf_pkg::job_t entry_reg [rscf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    assign full       = fill_reg == CNT_W'(rscf_pkg::QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(rscf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(rscf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hdl/rscf_back.sv */
// back end: walks the head job's step mask and drives the output register
// depends on rscf_pkg
module rscf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  rscf_pkg::job_t     head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [7:0]         state_id,
    output logic [3:0]         state_value,
    output logic [31:0]        sprite_count,
    output logic               last
);

    rscf_pkg::mask_t  sent_reg;
    rscf_pkg::mask_t  sent_next;
    rscf_pkg::mask_t  pending;
    rscf_pkg::step_t  step;
    rscf_pkg::write_t wr;
    logic             fire;
    logic             is_done;

    logic             valid_reg;
    rscf_pkg::kind_t  kind_reg;
    logic [7:0]       id_reg;
    logic [3:0]       value_reg;
    logic [31:0]      count_reg;
    logic             last_reg;

    // lowest step not yet sent; done is always pending
    assign pending = head_job.steps & ~sent_reg;

    always_comb
    begin
        step = rscf_pkg::ST_DONE;
        for (int i = rscf_pkg::NUM_STEPS - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                step = rscf_pkg::step_t'(5'(i));
            end
        end
    end

    assign wr      = rscf_pkg::step_write(step, head_job);
    assign is_done = step == rscf_pkg::ST_DONE;
    assign fire    = head_valid && (!valid_reg || out_ready);
    assign pop     = fire && is_done;

    // progress through the current job
    always_comb
    begin
        sent_next = sent_reg;
        if (fire)
        begin
            sent_next = is_done ? '0 : (sent_reg | (rscf_pkg::mask_t'(1) << step));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg <= sent_next;
            if (fire)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg  <= wr.kind;
            id_reg    <= wr.id;
            value_reg <= wr.value;
            count_reg <= is_done ? head_job.count : 32'd0;
            last_reg  <= is_done;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign state_id     = id_reg;
    assign state_value  = value_reg;
    assign sprite_count = count_reg;
    assign last         = last_reg;

endmodule

/* hdl/render_state_change_filter_chk.sv */
// port-level checker for the render state change filter, bound to the top level
// depends on rscf_pkg and render_state_change_filter_macros.svh
`include "render_state_change_filter_macros.svh"

module render_state_change_filter_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  state_id,
    input logic [3:0]  state_value,
    input logic [31:0] sprite_count,
    input logic        last
);

    // last marks done and nothing else
    `RSCF_IMPLY(a_last_is_done, out_valid, last == (kind == rscf_pkg::KIND_DONE), "last and done disagree")

    // counter only shows on done
    `RSCF_IMPLY(a_count_on_done, out_valid && !last, sprite_count == 32'd0, "counter on non-done result")

    // flush and done carry no state write
    `RSCF_IMPLY(a_empty_payload, out_valid && (kind == rscf_pkg::KIND_FLUSH || kind == rscf_pkg::KIND_DONE), state_id == 8'd0 && state_value == 4'd0, "flush or done with a state write")

    // a stalled result holds
    `RSCF_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(state_id) && $stable(state_value) && $stable(sprite_count), "stalled result changed")

    // a waiting sprite is not withdrawn
    `RSCF_NEXT(a_in_hold, in_valid && !in_ready, in_valid, "waiting sprite withdrawn")

endmodule

bind render_state_change_filter render_state_change_filter_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .state_id     (state_id),
    .state_value  (state_value),
    .sprite_count (sprite_count),
    .last         (last)
);
